// ===== design/quaternion_to_euler_angles_defines.svh =====
// assertion macros shared by the quaternion to euler angles design
// needs a clk and an active-low rst_n in the scope of each use
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`ifndef ASSERT_OFF
`define QTE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define QTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define QTE_ASSERT(lbl, cond)
`define QTE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== design/qte_pkg.sv =====
// shared types, widths and arctangent table for the quaternion to euler angles design
// no dependencies
package qte_pkg;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN = 24;
  localparam int IN_W = 16;
  localparam int ROLL_W = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W = 16;
  localparam int OP_W = 32;
  localparam int REM_W = 58;
  localparam int ROOT_W = 29;
  localparam int CX_W = 36;
  localparam int ANG_W = 28;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [ROLL_W-1:0] PI_LIM_Q13 = 16'sd25736;
  localparam logic signed [ROLL_W-1:0] HALF_PI_LIM_Q13 = 16'sd12868;

  typedef struct packed {
    logic signed [OP_W-1:0] t0;
    logic signed [OP_W-1:0] t1;
    logic signed [OP_W-1:0] t2;
    logic signed [OP_W-1:0] t3;
    logic signed [OP_W-1:0] t4;
  } ops_t;

  typedef struct packed {
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } lanes_t;

  // atan(2^-i) in q.24, rounded
  function automatic logic signed [ANG_W-1:0] atan_q24(input int idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0: a = 28'sd13176795;
      1: a = 28'sd7778716;
      2: a = 28'sd4110060;
      3: a = 28'sd2086331;
      4: a = 28'sd1047214;
      5: a = 28'sd524117;
      6: a = 28'sd262123;
      7: a = 28'sd131069;
      8: a = 28'sd65536;
      9: a = 28'sd32768;
      10: a = 28'sd16384;
      11: a = 28'sd8192;
      12: a = 28'sd4096;
      13: a = 28'sd2048;
      14: a = 28'sd1024;
      15: a = 28'sd512;
      16: a = 28'sd256;
      17: a = 28'sd128;
      18: a = 28'sd64;
      19: a = 28'sd32;
      20: a = 28'sd16;
      21: a = 28'sd8;
      22: a = 28'sd4;
      23: a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction
endpackage

// ===== design/qte_front.sv =====
// operand front end: quaternion products, saturated atan2 operands, 1 - t*t
// depends on qte_pkg
module qte_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ce,
  input  logic                             valid_i,
  input  logic signed [qte_pkg::IN_W-1:0]  w_i,
  input  logic signed [qte_pkg::IN_W-1:0]  x_i,
  input  logic signed [qte_pkg::IN_W-1:0]  y_i,
  input  logic signed [qte_pkg::IN_W-1:0]  z_i,
  output logic                             valid_o,
  output qte_pkg::ops_t                    ops_o,
  output logic [qte_pkg::REM_W-1:0]        rad_o
);
  import qte_pkg::*;

  localparam int SUM_W = 36;
  localparam logic signed [SUM_W-1:0] ONE_Q28 = 36'sd268435456;
  localparam logic signed [SUM_W-1:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO = -36'sd2147483648;
  localparam logic signed [OP_W-1:0] ONE_OP = 32'sd268435456;

  function automatic logic signed [OP_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [OP_W-1:0] r;
    if (v > SAT_HI) r = SAT_HI[OP_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[OP_W-1:0];
    else r = v[OP_W-1:0];
    return r;
  endfunction

  logic [2:0] vld_r;
  logic signed [OP_W-1:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;
  ops_t ops_b_r, ops_c_r;
  logic signed [OP_W-1:0] t2_sat;
  logic signed [OP_W-1:0] t2_nxt;
  logic [ROOT_W-1:0] mag;
  logic [REM_W-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[1:0], valid_i};
    end
  end

  // stage a: products, exact q4.28
  always_ff @(posedge clk) begin
    if (ce) begin
      wx_r <= OP_W'(w_i * x_i);
      yz_r <= OP_W'(y_i * z_i);
      xx_r <= OP_W'(x_i * x_i);
      yy_r <= OP_W'(y_i * y_i);
      wy_r <= OP_W'(w_i * y_i);
      zx_r <= OP_W'(z_i * x_i);
      wz_r <= OP_W'(w_i * z_i);
      xy_r <= OP_W'(x_i * y_i);
      zz_r <= OP_W'(z_i * z_i);
    end
  end

  // stage b: sums, saturated, pitch argument clamped to +-1
  always_comb begin
    t2_sat = sat32((SUM_W'(wy_r) - SUM_W'(zx_r)) <<< 1);
    if (t2_sat > ONE_OP) t2_nxt = ONE_OP;
    else if (t2_sat < -ONE_OP) t2_nxt = -ONE_OP;
    else t2_nxt = t2_sat;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ops_b_r.t0 <= sat32((SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1);
      ops_b_r.t1 <= sat32(ONE_Q28 - ((SUM_W'(xx_r) + SUM_W'(yy_r)) <<< 1));
      ops_b_r.t2 <= t2_nxt;
      ops_b_r.t3 <= sat32((SUM_W'(wz_r) + SUM_W'(xy_r)) <<< 1);
      ops_b_r.t4 <= sat32(ONE_Q28 - ((SUM_W'(yy_r) + SUM_W'(zz_r)) <<< 1));
    end
  end

  // stage c: radicand 2^56 - t2^2
  assign mag = ops_b_r.t2[OP_W-1] ? ROOT_W'(-ops_b_r.t2) : ROOT_W'(ops_b_r.t2);

  always_ff @(posedge clk) begin
    if (ce) begin
      ops_c_r <= ops_b_r;
      rad_r   <= (REM_W'(1) << 56) - REM_W'(mag * mag);
    end
  end

  assign valid_o = vld_r[2];
  assign ops_o   = ops_c_r;
  assign rad_o   = rad_r;
endmodule

// ===== design/qte_sqrt_cell.sv =====
// one restoring square root cell: settles one result bit per beat
// depends on qte_pkg
module qte_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ce,
  input  logic                         valid_i,
  input  logic [qte_pkg::REM_W-1:0]    rem_i,
  input  logic [qte_pkg::ROOT_W-1:0]   root_i,
  input  qte_pkg::ops_t                ops_i,
  output logic                         valid_o,
  output logic [qte_pkg::REM_W-1:0]    rem_o,
  output logic [qte_pkg::ROOT_W-1:0]   root_o,
  output qte_pkg::ops_t                ops_o
);
  import qte_pkg::*;

  localparam int CW = REM_W + 2;

  logic [CW-1:0] cand;
  logic          take;
  logic          valid_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  ops_t              ops_r;

  // (2*root + 2^bit) * 2^bit, root has no bits at or below bit yet
  assign cand = (CW'(root_i) << (BIT + 1)) | (CW'(1) << (2 * BIT));
  assign take = CW'(rem_i) >= cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r  <= take ? REM_W'(CW'(rem_i) - cand) : rem_i;
      root_r <= take ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
      ops_r  <= ops_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign ops_o   = ops_r;
endmodule

// ===== design/qte_cordic_cell.sv =====
// one vectoring cordic iteration applied to the roll, pitch and yaw lanes
// depends on qte_pkg
module qte_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ce,
  input  logic            valid_i,
  input  qte_pkg::lanes_t lanes_i,
  output logic            valid_o,
  output qte_pkg::lanes_t lanes_o
);
  import qte_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = atan_q24(IDX);

  function automatic lane_t step(input lane_t l);
    lane_t r;
    logic signed [CX_W-1:0] dx, dy;
    dx = l.y >>> IDX;
    dy = l.x >>> IDX;
    r = l;
    if (!l.y[CX_W-1]) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + ATAN;
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - ATAN;
    end
    return r;
  endfunction

  logic   valid_r;
  lanes_t lanes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lanes_r.roll  <= step(lanes_i.roll);
      lanes_r.pitch <= step(lanes_i.pitch);
      lanes_r.yaw   <= step(lanes_i.yaw);
    end
  end

  assign valid_o = valid_r;
  assign lanes_o = lanes_r;
endmodule

// ===== design/quaternion_to_euler_angles.sv =====
// pipeline: front end stages a, b and c, 29 square root cells, 1 pre-rotation register,
//   CORDIC_STAGES cordic cells (at most TABLE_LEN) and 1 output register
// throughput: one quaternion per cycle while not stalled; all cell chains advance on ce
// the whole pipeline holds only while a finished beat waits at the output
// reset: synchronous active-low rst_n clears every valid flag, payload is not reset
// depends on qte_pkg, qte_front, qte_sqrt_cell, qte_cordic_cell and the defines header
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], 0
);
  import qte_pkg::*;
  `include "quaternion_to_euler_angles_defines.svh"

  localparam int SQ_CELLS = ROOT_W;
  localparam int N_CELLS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  // whole pipeline advances unless a result beat is stuck at the output
  logic ce;
  logic out_valid_r;
  logic [47:0] out_data_r;

  assign ce        = out_tready || !out_valid_r;
  assign in_tready = ce;

  // front end: products, saturated operands, radicand
  logic              f_valid;
  ops_t              f_ops;
  logic [REM_W-1:0]  f_rad;

  qte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .valid_i (in_tvalid),
    .w_i     (in_tdata[15:0]),
    .x_i     (in_tdata[31:16]),
    .y_i     (in_tdata[47:32]),
    .z_i     (in_tdata[63:48]),
    .valid_o (f_valid),
    .ops_o   (f_ops),
    .rad_o   (f_rad)
  );

  // square root chain, most significant result bit first
  logic              sq_valid [SQ_CELLS+1];
  logic [REM_W-1:0]  sq_rem   [SQ_CELLS+1];
  logic [ROOT_W-1:0] sq_root  [SQ_CELLS+1];
  ops_t              sq_ops   [SQ_CELLS+1];

  assign sq_valid[0] = f_valid;
  assign sq_rem[0]   = f_rad;
  assign sq_root[0]  = '0;
  assign sq_ops[0]   = f_ops;

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
    qte_sqrt_cell #(.BIT(SQ_CELLS - 1 - g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .valid_i (sq_valid[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .ops_i   (sq_ops[g]),
      .valid_o (sq_valid[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .ops_o   (sq_ops[g+1])
    );
  end

  // quadrant pre-rotation into the cordic half plane, zero vector flagged
  function automatic lane_t prerot(input logic signed [OP_W-1:0] yv,
                                   input logic signed [OP_W-1:0] xv);
    lane_t l;
    l.x    = CX_W'(xv);
    l.y    = CX_W'(yv);
    l.z    = '0;
    l.zero = (xv == '0) && (yv == '0);
    if (xv[OP_W-1]) begin
      if (!yv[OP_W-1]) begin
        l.x = CX_W'(yv);
        l.y = -CX_W'(xv);
        l.z = HALF_PI_Q24;
      end else begin
        l.x = -CX_W'(yv);
        l.y = CX_W'(xv);
        l.z = -HALF_PI_Q24;
      end
    end
    return l;
  endfunction

  logic   pre_valid_r;
  lanes_t pre_lanes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (ce) begin
      pre_valid_r <= sq_valid[SQ_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pre_lanes_r.roll  <= prerot(sq_ops[SQ_CELLS].t0, sq_ops[SQ_CELLS].t1);
      pre_lanes_r.pitch <= prerot(sq_ops[SQ_CELLS].t2, OP_W'(sq_root[SQ_CELLS]));
      pre_lanes_r.yaw   <= prerot(sq_ops[SQ_CELLS].t3, sq_ops[SQ_CELLS].t4);
    end
  end

  // cordic chain
  logic   cd_valid [N_CELLS+1];
  lanes_t cd_lanes [N_CELLS+1];

  assign cd_valid[0] = pre_valid_r;
  assign cd_lanes[0] = pre_lanes_r;

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cordic
    qte_cordic_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .valid_i (cd_valid[g]),
      .lanes_i (cd_lanes[g]),
      .valid_o (cd_valid[g+1]),
      .lanes_o (cd_lanes[g+1])
    );
  end

  // round half up to q3.13 and saturate
  function automatic logic signed [ROLL_W-1:0] to_q13(input lane_t l,
                                                     input logic signed [ROLL_W-1:0] lim);
    logic signed [ANG_W-1:0] r;
    logic signed [ROLL_W-1:0] a;
    r = (l.z + ANG_W'(1024)) >>> 11;
    if (l.zero) a = '0;
    else if (r > ANG_W'(lim)) a = lim;
    else if (r < -ANG_W'(lim)) a = -lim;
    else a = ROLL_W'(r);
    return a;
  endfunction

  logic signed [ROLL_W-1:0] roll_q, pitch_q, yaw_q;

  assign roll_q  = to_q13(cd_lanes[N_CELLS].roll, PI_LIM_Q13);
  assign pitch_q = to_q13(cd_lanes[N_CELLS].pitch, HALF_PI_LIM_Q13);
  assign yaw_q   = to_q13(cd_lanes[N_CELLS].yaw, PI_LIM_Q13);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= cd_valid[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data_r <= {1'b0, yaw_q[YAW_W-1:0], pitch_q[PITCH_W-1:0], roll_q};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // square root never exceeds 1.0 in q.28
  `QTE_ASSERT_IMP(a_sqrt_range, sq_valid[SQ_CELLS], sq_root[SQ_CELLS] <= (ROOT_W'(1) << 28))
  // pitch stays within half pi
  `QTE_ASSERT_IMP(a_pitch_range, out_valid_r,
    ($signed(out_data_r[30:16]) <= 15'sd12868) && ($signed(out_data_r[30:16]) >= -15'sd12868))
  // a stalled output keeps the whole pipeline frozen
  `QTE_ASSERT_IMP(a_stall_ready, out_valid_r && !out_tready, !in_tready)
endmodule
